// ----- sv/psd_pkg.sv -----
// Package with the widths, constants and batch record of the standard deviation block.
`default_nettype none

package psd_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int COUNT_W   = 21;
    localparam int SUM_W     = 30;
    localparam int SQ_W      = 40;
    localparam int SQ_HALF   = SQ_W / 2;
    localparam int FRAC_BITS = 8;
    localparam int STD_W     = 17;
    localparam int MEAN_W    = 18;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(1048576);

    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = COUNT_W + SQ_W;
    localparam int DIV_W  = ACC_W + 2 * FRAC_BITS;
    localparam int DVS_W  = 2 * COUNT_W - 1;
    localparam int ROOT_W = 36;
    localparam int CNT_W  = 7;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    square_sum;
        logic               overflow;
    } psd_batch_t;

endpackage

`default_nettype wire

// ----- sv/psd_in_if.sv -----
// Sample channel interface: valid, ready and one sample with its last flag.
`default_nettype none

interface psd_in_if;

    logic                        valid;
    logic                        ready;
    logic [psd_pkg::SAMPLE_W-1:0] sample;
    logic                        last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);

endinterface

`default_nettype wire

// ----- sv/psd_out_if.sv -----
// Result channel interface: valid, ready and one batch result.
`default_nettype none

interface psd_out_if;

    logic                        valid;
    logic                        ready;
    logic [psd_pkg::STD_W-1:0]   std_dev;
    logic [psd_pkg::MEAN_W-1:0]  mean;
    logic [psd_pkg::COUNT_W-1:0] count;
    logic                        overflow;

    modport source (output valid, output std_dev, output mean, output count,
                    output overflow, input ready);
    modport sink   (input valid, input std_dev, input mean, input count,
                    input overflow, output ready);

endinterface

`default_nettype wire

// ----- sv/psd_front.sv -----
// Front end: accumulates count, sum and sum of squares and hands off each finished batch.
`default_nettype none

module psd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    psd_in_if.sink                  samples,
    input  wire logic               q_ready,
    output logic                    q_push,
    output psd_pkg::psd_batch_t     q_data
);
    import psd_pkg::*;

    logic [COUNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic                  ovf_reg;
    logic                  accept;
    logic                  full;
    logic [2*SAMPLE_W-1:0] square;
    psd_batch_t            upd;

    assign samples.ready = q_ready;
    assign accept        = samples.valid && samples.ready;
    assign full          = (count_reg == MAX_COUNT);
    assign square        = samples.sample * samples.sample;

    always_comb
    begin
        upd.overflow = ovf_reg | full;
        if (full)
        begin
            upd.count      = count_reg;
            upd.sum        = sum_reg;
            upd.square_sum = sq_reg;
        end
        else
        begin
            upd.count      = count_reg + COUNT_W'(1);
            upd.sum        = sum_reg + SUM_W'(samples.sample);
            upd.square_sum = sq_reg + SQ_W'(square);
        end
    end

    assign q_push = accept && samples.last;
    assign q_data = upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (samples.last)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sq_reg    <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= upd.count;
                sum_reg   <= upd.sum;
                sq_reg    <= upd.square_sum;
                ovf_reg   <= upd.overflow;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/psd_queue.sv -----
// Two-entry queue of finished batches between the front end and the back end.
`default_nettype none

module psd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  psd_pkg::psd_batch_t     push_data,
    output logic                    not_full,
    input  wire logic               pop,
    output logic                    not_empty,
    output psd_pkg::psd_batch_t     pop_data
);
    import psd_pkg::*;

    psd_batch_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign not_full  = (fill_reg != 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/psd_back.sv -----
// Back end: sequences the products, the two divisions and the square root of one batch.
`default_nettype none

module psd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  psd_pkg::psd_batch_t     q_data,
    output logic                    q_pop,
    psd_out_if.source               results
);
    import psd_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MUL_LO    = 4'd1;
    localparam logic [3:0] ST_MUL_HI    = 4'd2;
    localparam logic [3:0] ST_MUL_SQ    = 4'd3;
    localparam logic [3:0] ST_MUL_NN    = 4'd4;
    localparam logic [3:0] ST_MEAN_INIT = 4'd5;
    localparam logic [3:0] ST_MEAN_DIV  = 4'd6;
    localparam logic [3:0] ST_VAR_DIV   = 4'd7;
    localparam logic [3:0] ST_SQRT      = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0]  SQRT_LAST = CNT_W'(ROOT_W / 2 - 1);
    localparam logic [ROOT_W-1:0] BIT_INIT  = ROOT_W'(1) << (ROOT_W - 2);

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [COUNT_W-1:0]  n_reg;
    logic [SUM_W-1:0]    s1_reg;
    logic [SQ_W-1:0]     s2_reg;
    logic                ovf_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [DVS_W-1:0]    nsq_reg;
    logic [DIV_W-1:0]    numq_reg;
    logic [DVS_W-1:0]    rem_reg;
    logic [DVS_W-1:0]    div_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ROOT_W-1:0]   x_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W-1:0]   bit_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic [STD_W-1:0]    std_reg;
    logic                out_valid_reg;
    logic [STD_W-1:0]    out_std_reg;
    logic [MEAN_W-1:0]   out_mean_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_ovf_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [DVS_W:0]      rem_shift;
    logic [DVS_W+1:0]    rem_diff;
    logic                borrow;
    logic [DVS_W-1:0]    rem_next;
    logic [DIV_W-1:0]    numq_next;
    logic [ROOT_W:0]     trial;
    logic                take;
    logic [ROOT_W-1:0]   x_next;
    logic [ROOT_W-1:0]   root_next;
    logic                load_out;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    always_comb
    begin
        mul_a = MUL_W'(n_reg);
        mul_b = MUL_W'(n_reg);
        case (state_reg)
            ST_MUL_LO:
            begin
                mul_b = MUL_W'(s2_reg[SQ_HALF-1:0]);
            end
            ST_MUL_HI:
            begin
                mul_b = MUL_W'(s2_reg[SQ_W-1:SQ_HALF]);
            end
            ST_MUL_SQ:
            begin
                mul_a = MUL_W'(s1_reg);
                mul_b = MUL_W'(s1_reg);
            end
            default:
            begin
                mul_b = MUL_W'(n_reg);
            end
        endcase
    end

    assign rem_shift = {rem_reg, numq_reg[DIV_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_reg};
    assign borrow    = rem_diff[DVS_W+1];
    assign rem_next  = borrow ? rem_shift[DVS_W-1:0] : rem_diff[DVS_W-1:0];
    assign numq_next = {numq_reg[DIV_W-2:0], !borrow};

    assign trial     = {1'b0, root_reg} + {1'b0, bit_reg};
    assign take      = ({1'b0, x_reg} >= trial);
    assign x_next    = take ? (x_reg - trial[ROOT_W-1:0]) : x_reg;
    assign root_next = take ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (q_valid) state_next = ST_MUL_LO;
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_MUL_SQ;
            ST_MUL_SQ:    state_next = ST_MUL_NN;
            ST_MUL_NN:    state_next = ST_MEAN_INIT;
            ST_MEAN_INIT: state_next = ST_MEAN_DIV;
            ST_MEAN_DIV:  if (cnt_reg == DIV_LAST) state_next = ST_VAR_DIV;
            ST_VAR_DIV:   if (cnt_reg == DIV_LAST) state_next = ST_SQRT;
            ST_SQRT:      if (cnt_reg == SQRT_LAST) state_next = ST_DONE;
            ST_DONE:      if (load_out) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                n_reg   <= q_data.count;
                s1_reg  <= q_data.sum;
                s2_reg  <= q_data.square_sum;
                ovf_reg <= q_data.overflow;
            end
            ST_MUL_HI:
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            ST_MUL_SQ:
            begin
                acc_reg <= acc_reg + (ACC_W'(prod_reg) << SQ_HALF);
            end
            ST_MUL_NN:
            begin
                acc_reg <= acc_reg - ACC_W'(prod_reg);
            end
            ST_MEAN_INIT:
            begin
                nsq_reg  <= prod_reg[DVS_W-1:0];
                numq_reg <= DIV_W'(s1_reg) << FRAC_BITS;
                div_reg  <= DVS_W'(n_reg);
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            ST_MEAN_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    mean_reg <= numq_next[MEAN_W-1:0];
                    numq_reg <= DIV_W'(acc_reg) << (2 * FRAC_BITS);
                    div_reg  <= nsq_reg;
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    numq_reg <= numq_next;
                    rem_reg  <= rem_next;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                end
            end
            ST_VAR_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    x_reg    <= numq_next[ROOT_W-1:0];
                    root_reg <= '0;
                    bit_reg  <= BIT_INIT;
                    cnt_reg  <= '0;
                end
                else
                begin
                    numq_reg <= numq_next;
                    rem_reg  <= rem_next;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                end
            end
            ST_SQRT:
            begin
                x_reg    <= x_next;
                root_reg <= root_next;
                bit_reg  <= bit_reg >> 2;
                cnt_reg  <= cnt_reg + CNT_W'(1);
                if (cnt_reg == SQRT_LAST)
                begin
                    std_reg <= root_next[STD_W-1:0];
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
        if (load_out)
        begin
            out_std_reg   <= std_reg;
            out_mean_reg  <= mean_reg;
            out_count_reg <= n_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.std_dev  = out_std_reg;
    assign results.mean     = out_mean_reg;
    assign results.count    = out_count_reg;
    assign results.overflow = out_ovf_reg;

endmodule

`default_nettype wire

// ----- sv/population_std_deviation.sv -----
// Top level of the population standard deviation block: front end, batch queue, back end.
//
//   Channel   Modport  Transaction payload
//   samples   sink     sample[9:0], last
//   results   source   std_dev[16:0], mean[17:0], count[20:0], overflow
//
// One sample is taken each cycle while the batch queue has room; the front-end accumulators
// add it as it is taken. Each batch then passes through the back end: four passes through the
// shared 32x32 multiplier, two 77-step restoring divisions and an 18-step square root.
// A two-entry batch queue lets sampling continue while the back end works; samples
// stall only when two finished batches are already waiting. Reset clears control and accumulators.
`default_nettype none

module population_std_deviation (
    input  wire logic clk,
    input  wire logic rst_n,
    psd_in_if.sink    samples,
    psd_out_if.source results
);
    import psd_pkg::*;

    logic       q_push;
    logic       q_ready;
    logic       q_valid;
    logic       q_pop;
    psd_batch_t q_in;
    psd_batch_t q_out;

    psd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    psd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    psd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .results (results)
    );

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("Batch pushed into a full queue.");

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready && samples.last) |-> q_push)
        else $error("Final sample did not hand off its batch.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.count != '0 && results.count <= MAX_COUNT))
        else $error("Result count out of range.");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.overflow) |-> (results.count == MAX_COUNT))
        else $error("Overflow flagged on a batch that was not full.");

endmodule

`default_nettype wire

// ----- dv/psd_stats_checker.sv -----
// Checker that predicts each batch result of the standard deviation block and compares it.
module psd_stats_checker
    import psd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    psd_in_if    samples,
    psd_out_if   results,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [STD_W-1:0]   std_dev;
        logic [MEAN_W-1:0]  mean;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } batch_stats_t;

    batch_stats_t expected_stats[$];

    logic [63:0] batch_count;
    logic [63:0] batch_sum;
    logic [63:0] batch_squares;
    logic        batch_dropped;

    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if ({32'd0, trial} * {32'd0, trial} <= x)
                root = trial;
        end
        return root;
    endfunction

    function automatic batch_stats_t batch_stats(input logic [63:0] n,
                                                 input logic [63:0] sum,
                                                 input logic [63:0] squares,
                                                 input logic        dropped);
        batch_stats_t stats;
        logic [63:0]  mean_full;
        logic [127:0] spread;
        logic [127:0] variance;
        mean_full = '0;
        variance  = '0;
        if (n != 0) begin
            mean_full = (sum << FRAC_BITS) / n;
            spread    = (n * squares - sum * sum) << (2 * FRAC_BITS);
            variance  = spread / (n * n);
        end
        stats.std_dev  = STD_W'(floor_sqrt(variance[63:0]));
        stats.mean     = MEAN_W'(mean_full);
        stats.count    = COUNT_W'(n);
        stats.overflow = dropped;
        return stats;
    endfunction

    task automatic flag_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        mismatches = mismatches + 1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin
        batch_stats_t want;
        if (!rst_n) begin
            expected_stats.delete();
            batch_count   = '0;
            batch_sum     = '0;
            batch_squares = '0;
            batch_dropped = 1'b0;
            mismatches    = 0;
            outstanding <= 0;
        end else begin
            if (results.valid && results.ready) begin
                if (expected_stats.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected result, expected none, actual count %0d",
                             $time, results.count);
                end else begin
                    want = expected_stats.pop_front();
                    if (results.std_dev !== want.std_dev)
                        flag_field("std_dev", want.std_dev, results.std_dev);
                    if (results.mean !== want.mean)
                        flag_field("mean", want.mean, results.mean);
                    if (results.count !== want.count)
                        flag_field("count", want.count, results.count);
                    if (results.overflow !== want.overflow)
                        flag_field("overflow", want.overflow, results.overflow);
                end
            end
            if (samples.valid && samples.ready) begin
                if (batch_count < 64'(MAX_COUNT)) begin
                    batch_count   = batch_count + 1;
                    batch_sum     = batch_sum + 64'(samples.sample);
                    batch_squares = batch_squares + 64'(samples.sample) * 64'(samples.sample);
                end else begin
                    batch_dropped = 1'b1;
                end
                if (samples.last) begin
                    expected_stats.push_back(batch_stats(batch_count, batch_sum,
                                                         batch_squares, batch_dropped));
                    batch_count   = '0;
                    batch_sum     = '0;
                    batch_squares = '0;
                    batch_dropped = 1'b0;
                end
            end
            outstanding <= expected_stats.size();
        end
    end

endmodule

// ----- dv/population_std_deviation_tb.sv -----
// Top of the standard deviation testbench: clock, reset, sample and result traffic, verdict.
module population_std_deviation_tb;

    import psd_pkg::*;

    localparam int RANDOM_ITEMS   = 1550;
    localparam int HOLD_CYCLES    = 800;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 400;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_EXTREME,
        SHAPE_CONSTANT,
        SHAPE_NARROW
    } sample_shape_t;

    logic clk;
    logic rst_n;
    logic tx_idle;
    logic stall_request;
    logic stall_served;
    int   mismatches;
    int   outstanding;
    int   idle_cycles;

    psd_in_if  samples_if ();
    psd_out_if results_if ();

    population_std_deviation u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    psd_stats_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_if),
        .results     (results_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= value;
        samples_if.last   <= is_last;
        @(posedge clk);
        while (!(samples_if.valid && samples_if.ready)) @(posedge clk);
    endtask

    task automatic send_values(input logic [SAMPLE_W-1:0] values[$]);
        foreach (values[i])
            push_sample(values[i], i == values.size() - 1);
    endtask

    task automatic send_batch(input int length, input sample_shape_t shape);
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] value;
        base = SAMPLE_W'($urandom);
        for (int i = 0; i < length; i++) begin
            case (shape)
                SHAPE_UNIFORM:  value = SAMPLE_W'($urandom);
                SHAPE_EXTREME:  value = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                SHAPE_CONSTANT: value = base;
                default:        value = base ^ SAMPLE_W'($urandom_range(0, 7));
            endcase
            push_sample(value, i == length - 1);
        end
    endtask

    initial begin
        int taken;
        int gap;
        logic rx_idle;
        taken   = 0;
        rx_idle = 1'b1;
        stall_served = 1'b0;
        results_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (stall_request && !stall_served) begin
                stall_served = 1'b1;
                gap = HOLD_CYCLES;
            end else begin
                gap = rx_idle ? $urandom_range(0, 3) : 0;
            end
            if (gap > 0) begin
                results_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            @(posedge clk);
            while (!(results_if.valid && results_if.ready)) @(posedge clk);
            taken++;
            if (taken % 16 == 0)
                rx_idle = ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (samples_if.valid && samples_if.ready)
                   || (results_if.valid && results_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int items_sent;
        int length;
        items_sent = 0;
        tx_idle    = 1'b1;
        rst_n             <= 1'b0;
        stall_request     <= 1'b0;
        samples_if.valid  <= 1'b0;
        samples_if.sample <= '0;
        samples_if.last   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_values('{10'd0});
        send_values('{SAMPLE_MAX});
        send_values('{10'd0, SAMPLE_MAX});
        send_values('{SAMPLE_MAX, 10'd0, SAMPLE_MAX, 10'd0});
        send_values('{10'h155, 10'h2AA, 10'h155});
        send_values('{10'd1, 10'd2, 10'd3, 10'd4, 10'd5});
        send_values('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});

        // Hold the results back while batches keep coming, so the input stalls.
        tx_idle = 1'b0;
        stall_request <= 1'b1;
        repeat (8) send_batch(3, SHAPE_UNIFORM);

        while (items_sent < RANDOM_ITEMS) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                 : $urandom_range(1, 12);
            tx_idle = ($urandom_range(0, 3) != 0);
            send_batch(length, sample_shape_t'($urandom_range(0, 3)));
            items_sent += length;
        end
        samples_if.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/psd_pkg.sv
sv/psd_in_if.sv
sv/psd_out_if.sv
sv/psd_front.sv
sv/psd_queue.sv
sv/psd_back.sv
sv/population_std_deviation.sv
dv/psd_stats_checker.sv
dv/population_std_deviation_tb.sv
